/* sv/u8v_pkg.sv */
// ============================================================================
// u8v_pkg
// Shared types, codes and UTF-8 classification functions of the filter.
// ============================================================================
`default_nettype none

package u8v_pkg;

    // Sequence length that a lead byte announces; zero marks a byte that
    // cannot start a character.
    typedef logic [2:0] need_t;

    localparam need_t NEED_BAD = 3'd0;
    localparam need_t NEED_1   = 3'd1;
    localparam need_t NEED_2   = 3'd2;
    localparam need_t NEED_3   = 3'd3;
    localparam need_t NEED_4   = 3'd4;

    // One queued byte together with its classification.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        need_t      need;
    } entry_t;

    function automatic need_t seq_need(input logic [7:0] b);
        need_t n;
        if (b[7] == 1'b0) begin
            n = NEED_1;
        end
        else if (b[7:5] == 3'b110) begin
            n = NEED_2;
        end
        else if (b[7:4] == 4'b1110) begin
            n = NEED_3;
        end
        else if (b[7:3] == 5'b11110) begin
            n = NEED_4;
        end
        else begin
            n = NEED_BAD;
        end
        return n;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b[7:6] == 2'b10);
    endfunction

    // Checks the sequence that starts at b0 for the given length.
    function automatic logic seq_ok(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b3,
        input need_t      need
    );
        logic        ok;
        logic [3:0]  z;
        logic [11:0] low;
        logic [4:0]  plane;
        z     = b0[3:0];
        low   = {b1[5:0], b2[5:0]};
        plane = {b0[2:0], b1[5:4]};
        case (need)
            NEED_1: begin
                ok = 1'b1;
            end
            NEED_2: begin
                ok = is_cont(b1) && (b0[4:0] > 5'h01);
            end
            NEED_3: begin
                ok = is_cont(b1) && is_cont(b2);
                // Overlong form: E0 needs a second byte of A0-BF.
                if (z == 4'h0 && b1[5] == 1'b0) begin
                    ok = 1'b0;
                end
                // Surrogates D800-DFFF.
                if (z == 4'hd && low[11]) begin
                    ok = 1'b0;
                end
                // Noncharacters FFFE, FFFF and FDD0-FDEF.
                if (z == 4'hf) begin
                    if (low[11:1] == 11'h7ff) begin
                        ok = 1'b0;
                    end
                    if (low >= 12'hdd0 && low <= 12'hdef) begin
                        ok = 1'b0;
                    end
                end
            end
            NEED_4: begin
                ok = is_cont(b1) && is_cont(b2) && is_cont(b3);
                if (plane == 5'h00 || plane > 5'h10) begin
                    ok = 1'b0;
                end
                if (b1[3:0] == 4'hf && b2[5:0] == 6'h3f && b3[5:1] == 5'h1f) begin
                    ok = 1'b0;
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

/* sv/u8v_if.sv */
// ============================================================================
// u8v_if
// Valid/ready channels of the filter: the raw byte input and the result output.
// ============================================================================
`default_nettype none

interface u8v_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface u8v_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;

    modport source (output valid, output out_byte, output out_valid, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input out_valid, input out_last,
                    output ready);
endinterface

`default_nettype wire

/* sv/utf8_stream_validator_filter_top.sv */
// ============================================================================
// utf8_stream_validator_filter_top
// Streaming UTF-8 validator that passes only bytes of well-formed characters.
// ============================================================================
// The block takes a string one byte per transfer on in_ch and returns the
// bytes of well-formed UTF-8 characters on out_ch, in order. When the
// sequence starting at the oldest held byte is invalid, only that lead byte
// is dropped and scanning resumes at the next byte. Overlong forms,
// surrogates, planes outside 1 to 16, the noncharacters FDD0-FDEF and
// xFFFE/xFFFF, and broken continuation bytes are rejected. The end of the
// string is marked by in_last; the final result carries out_last, and if the
// final byte yields no result a bare end marker (out_valid 0, out_last 1)
// is sent. A sequence still incomplete at the end is dropped. With utf8_mode
// cleared (cfg_wr_data 0), every byte passes unchanged and held bytes are
// discarded; the mode resets to 1 and may be written only while the block is
// idle. A front stage classifies each byte into a short queue of
// QUEUE_DEPTH entries, so input transfers continue while the scan engine
// works. The scan engine handles one byte per visit: it takes the byte,
// drops each rejected lead byte in a step of its own, checks each complete
// sequence and then emits its bytes one at a time, and closes the visit
// with a flush step. Pass-through mode takes each byte and then emits it
// unchanged. The result register toward out_ch frees the engine from a
// stalled sink until a second result is ready.
// ============================================================================
`default_nettype none

module utf8_stream_validator_filter_top
    import u8v_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    u8v_in_if.sink     in_ch,
    u8v_out_if.source  out_ch,
    input  wire logic  cfg_wr_en,
    input  wire logic  cfg_wr_data
);

    logic   mode_reg, mode_next;
    logic   push_valid;
    logic   push_ready;
    entry_t push_data;
    logic   q_valid;
    logic   q_pop;
    entry_t q_data;

    // Mode register: one bit, written whenever the write enable is high.
    assign mode_next = cfg_wr_en ? cfg_wr_data : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= 1'b1;
        end
        else begin
            mode_reg <= mode_next;
        end
    end

    // Front: takes bytes and tags each with its announced sequence length.
    u8v_front u_front (
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Queue between the front and the scan engine.
    u8v_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_data   (q_data)
    );

    // Back: holds partial sequences, validates and emits results.
    u8v_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .mode    (mode_reg),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data),
        .out_ch  (out_ch)
    );

endmodule

`default_nettype wire

/* sv/u8v_queue.sv */
// ============================================================================
// u8v_queue
// Short first-in first-out queue of classified bytes between front and back.
// ============================================================================
`default_nettype none

module u8v_queue
    import u8v_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push_valid,
    output      logic   push_ready,
    input  wire entry_t push_data,
    output      logic   pop_valid,
    input  wire logic   pop_ready,
    output      entry_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == FULL_CNT) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not follow a pop");

endmodule

`default_nettype wire

/* sv/u8v_front.sv */
// ============================================================================
// u8v_front
// Accepts raw bytes and tags each with the sequence length its value announces.
// ============================================================================
`default_nettype none

module u8v_front
    import u8v_pkg::*;
(
    u8v_in_if.sink    in_ch,
    output    logic   push_valid,
    input wire logic  push_ready,
    output    entry_t push_data
);

    // A byte is taken whenever the queue has room.
    assign in_ch.ready     = push_ready;
    assign push_valid      = in_ch.valid;
    assign push_data.data  = in_ch.in_byte;
    assign push_data.last  = in_ch.in_last;
    assign push_data.need  = seq_need(in_ch.in_byte);

endmodule

`default_nettype wire

/* sv/u8v_back.sv */
// ============================================================================
// u8v_back
// Scan engine: holds incomplete sequences, validates, and emits result bytes.
// ============================================================================
`default_nettype none

module u8v_back
    import u8v_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   mode,
    input  wire logic   q_valid,
    output      logic   q_pop,
    input  wire entry_t q_data,
    u8v_out_if.source   out_ch
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_EMIT  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  pend_reg [4];
    logic [7:0]  pend_next [4];
    need_t       need_reg [4];
    need_t       need_next [4];
    logic [2:0]  cnt_reg, cnt_next;
    logic [2:0]  rem_reg, rem_next;
    logic        last_reg, last_next;
    logic        pass_reg, pass_next;
    logic        held_v_reg, held_v_next;
    logic [7:0]  held_reg, held_next;
    logic        ov_reg, ov_next;
    logic [7:0]  ob_reg, ob_next;
    logic        ofv_reg, ofv_next;
    logic        ol_reg, ol_next;
    logic        slot_free;
    logic        do_shift;
    logic        head_ok;

    assign slot_free = !ov_reg || out_ch.ready;
    assign head_ok   = seq_ok(pend_reg[0], pend_reg[1], pend_reg[2], pend_reg[3],
                              need_reg[0]);

    assign out_ch.valid     = ov_reg;
    assign out_ch.out_byte  = ob_reg;
    assign out_ch.out_valid = ofv_reg;
    assign out_ch.out_last  = ol_reg;

    always_comb
    begin
        state_next  = state_reg;
        pend_next   = pend_reg;
        need_next   = need_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        last_next   = last_reg;
        pass_next   = pass_reg;
        held_v_next = held_v_reg;
        held_next   = held_reg;
        ov_next     = ov_reg && !out_ch.ready;
        ob_next     = ob_reg;
        ofv_next    = ofv_reg;
        ol_next     = ol_reg;
        q_pop       = 1'b0;
        do_shift    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    last_next = q_data.last;
                    if (!mode) begin
                        pend_next[0] = q_data.data;
                        cnt_next     = 3'd1;
                        pass_next    = 1'b1;
                    end
                    else begin
                        pend_next[cnt_reg[1:0]] = q_data.data;
                        need_next[cnt_reg[1:0]] = q_data.need;
                        cnt_next                = cnt_reg + 3'd1;
                        pass_next               = 1'b0;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (pass_reg) begin
                    if (slot_free) begin
                        ov_next    = 1'b1;
                        ob_next    = pend_reg[0];
                        ofv_next   = 1'b1;
                        ol_next    = last_reg;
                        cnt_next   = 3'd0;
                        state_next = ST_IDLE;
                    end
                end
                else if (cnt_reg == 3'd0) begin
                    state_next = ST_FLUSH;
                end
                else if (need_reg[0] == NEED_BAD) begin
                    do_shift = 1'b1;
                end
                else if (cnt_reg < need_reg[0]) begin
                    // Too short: wait for more bytes, or give up at the end.
                    if (last_reg) begin
                        do_shift = 1'b1;
                    end
                    else begin
                        state_next = ST_FLUSH;
                    end
                end
                else if (head_ok) begin
                    rem_next   = need_reg[0];
                    state_next = ST_EMIT;
                end
                else begin
                    do_shift = 1'b1;
                end
            end
            ST_EMIT: begin
                // The newest result waits in the held register so that the
                // end-of-string flag can still be put on it.
                if (!held_v_reg || slot_free) begin
                    if (held_v_reg) begin
                        ov_next  = 1'b1;
                        ob_next  = held_reg;
                        ofv_next = 1'b1;
                        ol_next  = 1'b0;
                    end
                    held_v_next = 1'b1;
                    held_next   = pend_reg[0];
                    do_shift    = 1'b1;
                    rem_next    = rem_reg - 3'd1;
                    if (rem_reg == 3'd1) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_FLUSH: begin
                if (!(held_v_reg || last_reg) || slot_free) begin
                    if (held_v_reg) begin
                        ov_next     = 1'b1;
                        ob_next     = held_reg;
                        ofv_next    = 1'b1;
                        ol_next     = last_reg;
                        held_v_next = 1'b0;
                    end
                    else if (last_reg) begin
                        ov_next  = 1'b1;
                        ob_next  = 8'h00;
                        ofv_next = 1'b0;
                        ol_next  = 1'b1;
                    end
                    if (last_reg) begin
                        cnt_next = 3'd0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_shift) begin
            for (int i = 0; i < 3; i++) begin
                pend_next[i] = pend_reg[i+1];
                need_next[i] = need_reg[i+1];
            end
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= 3'd0;
            rem_reg    <= 3'd0;
            last_reg   <= 1'b0;
            pass_reg   <= 1'b0;
            held_v_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rem_reg    <= rem_next;
            last_reg   <= last_next;
            pass_reg   <= pass_next;
            held_v_reg <= held_v_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        need_reg <= need_next;
        held_reg <= held_next;
        ob_reg   <= ob_next;
        ofv_reg  <= ofv_next;
        ol_reg   <= ol_next;
    end

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (cnt_reg <= 3'd3))
        else $error("more than three bytes held between transfers");

    a_idle_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !held_v_reg)
        else $error("result left in held register after a transfer");

    a_emit_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (rem_reg != 3'd0 && rem_reg <= cnt_reg))
        else $error("emit count out of range");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == ST_SCAN))
        else $error("popped byte not scanned");

endmodule

`default_nettype wire

/* sim/tb_utf8_stream_validator_filter_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_utf8_stream_validator_filter_top
// Self-checking bench for the streaming UTF-8 validating filter.
// ============================================================================
// Strings of bytes are sent through the input channel and every result on
// the output channel is checked against a predictor kept in this bench.
// The predictor tracks the held bytes and the mode register.
// A short directed string covers the corner cases of the UTF-8 rules.
// Random phases then alternate between validation and pass-through.
// Validation phases use mostly well-formed characters with random content
// mixed with noise and broken sequences; pass-through phases use raw bytes.
// Both channels idle at random, except in one phase that runs at full rate.
// ============================================================================

module tb_utf8_stream_validator_filter_top;

    // Values of the mode register.
    localparam logic MODE_PASS = 1'b0;
    localparam logic MODE_UTF8 = 1'b1;

    // Idle share of each channel, in percent.
    localparam int IDLE_PCT = 31;

    // Cycles granted to the block after the last expected result before the
    // mode register is written or the run ends. A byte that only joins or
    // breaks a sequence can keep the scan engine busy while no result appears.
    localparam int SETTLE_CYCLES = 40;

    // Mismatches that are printed in full; later ones are only counted.
    localparam int MAX_REPORTS = 10;

    // One byte of a string, as sent on the input channel.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } string_byte_t;

    // One result of the filter, as expected on the output channel.
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } kept_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    u8v_in_if  in_ch ();
    u8v_out_if out_ch ();

    utf8_stream_validator_filter_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Bytes waiting to be sent, and the bytes the filter should pass on.
    string_byte_t string_bytes_q[$];
    kept_t        kept_q[$];

    // Scratch buffer used while a random string is built.
    logic [7:0]   text_q[$];

    // Predictor state: bytes of an unfinished character and the mode.
    logic [7:0]   held_bytes [4];
    int           held_n;
    logic         utf8_mode_q;

    int           pushed_cnt;
    int           taken_cnt;
    int           err_n;
    logic         in_taken;
    logic         no_idle;

    // The clock runs with a period of 8 ns.
    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------------

    function automatic logic is_trail(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // Number of bytes that a lead byte announces; zero for a byte that
    // cannot start a character.
    function automatic int char_len(input logic [7:0] b);
        casez (b)
            8'b0???????: return 1;
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 0;
        endcase
    endfunction

    // The checks are written on the decoded code point, which is the plain
    // statement of the rules: no overlong forms, no surrogates, no
    // noncharacters at FDD0-FDEF or at the end of a plane, planes 1 to 16.
    function automatic logic seq_well_formed(input logic [7:0] b0, b1, b2, b3,
                                             input int len);
        logic [15:0] cp3;
        logic [20:0] cp4;
        cp3 = {b0[3:0], b1[5:0], b2[5:0]};
        cp4 = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        case (len)
            1: return 1'b1;
            2: return is_trail(b1) && (b0 >= 8'hC2);
            3: return is_trail(b1) && is_trail(b2)
                   && (cp3 >= 16'h0800)
                   && !(cp3 >= 16'hD800 && cp3 <= 16'hDFFF)
                   && !(cp3 >= 16'hFDD0 && cp3 <= 16'hFDEF)
                   && (cp3 < 16'hFFFE);
            4: return is_trail(b1) && is_trail(b2) && is_trail(b3)
                   && (cp4[20:16] >= 5'd1) && (cp4[20:16] <= 5'd16)
                   && (cp4[15:1] != 15'h7FFF);
            default: return 1'b0;
        endcase
    endfunction

    // Removes k bytes from the front of the held sequence.
    task automatic shift_held(input int k);
        for (int i = 0; i < 4; i++) begin
            held_bytes[i] = (i + k < 4) ? held_bytes[i + k] : 8'h00;
        end
        held_n = held_n - k;
    endtask

    // Works out the results that one accepted byte causes and queues them.
    task automatic filter_byte(input logic [7:0] b, input logic is_last);
        kept_t outs [4];
        int    n_out;
        int    len;
        n_out = 0;
        if (utf8_mode_q == MODE_PASS) begin
            // Pass-through forgets anything held from an earlier string.
            held_n = 0;
            kept_q.push_back('{data: b, valid: 1'b1, last: is_last});
            return;
        end
        held_bytes[held_n] = b;
        held_n++;
        // Scan from the oldest held byte; a bad lead costs one byte only, so
        // the bytes behind it are looked at again.
        while (held_n > 0) begin
            len = char_len(held_bytes[0]);
            if (len == 0) begin
                shift_held(1);
            end
            else if (held_n < len) begin
                if (!is_last) begin
                    break;
                end
                shift_held(1);
            end
            else if (seq_well_formed(held_bytes[0], held_bytes[1], held_bytes[2],
                                     held_bytes[3], len)) begin
                for (int i = 0; i < len; i++) begin
                    outs[n_out] = '{data: held_bytes[i], valid: 1'b1, last: 1'b0};
                    n_out++;
                end
                shift_held(len);
            end
            else begin
                shift_held(1);
            end
        end
        if (is_last) begin
            held_n = 0;
            // A last byte that yields nothing still closes the string with a bare marker.
            if (n_out == 0) begin
                outs[0] = '{data: 8'h00, valid: 1'b0, last: 1'b1};
                n_out   = 1;
            end
            else begin
                outs[n_out - 1].last = 1'b1;
            end
        end
        for (int i = 0; i < n_out; i++) begin
            kept_q.push_back(outs[i]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: one byte per transfer, fed from string_bytes_q. A byte that is
    // offered stays on the channel until the transfer happens.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin : drive_proc
        string_byte_t nxt;
        if (rst_n && (!in_ch.valid || in_taken)) begin
            if (string_bytes_q.size() > 0
                && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                nxt = string_bytes_q.pop_front();
                in_ch.valid   <= 1'b1;
                in_ch.in_byte <= nxt.data;
                in_ch.in_last <= nxt.last;
            end
            else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // The output side stalls at random, except in the full-rate phase.
    always @(negedge clk) begin
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Monitor: input transfers feed the predictor, output transfers are
    // checked against the oldest expected result.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : check_proc
        kept_t want;
        if (!rst_n) begin
            in_taken <= 1'b0;
        end
        else begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                filter_byte(in_ch.in_byte, in_ch.in_last);
                taken_cnt++;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (kept_q.size() == 0) begin
                    if (err_n < MAX_REPORTS) begin
                        $display("%0t: unexpected result byte %02h valid %0b last %0b",
                                 $realtime, out_ch.out_byte, out_ch.out_valid,
                                 out_ch.out_last);
                    end
                    err_n++;
                end
                else begin
                    want = kept_q.pop_front();
                    if (out_ch.out_byte !== want.data || out_ch.out_valid !== want.valid
                        || out_ch.out_last !== want.last) begin
                        if (err_n < MAX_REPORTS) begin
                            $display({"%0t: mismatch, expected byte %02h valid %0b last %0b,",
                                      " got byte %02h valid %0b last %0b"},
                                     $realtime, want.data, want.valid, want.last,
                                     out_ch.out_byte, out_ch.out_valid, out_ch.out_last);
                        end
                        err_n++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    task automatic add_byte(input logic [7:0] b, input logic is_last);
        string_bytes_q.push_back('{data: b, last: is_last});
        pushed_cnt++;
    endtask

    function automatic logic [7:0] trail_byte();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    // Appends one character to text_q: mostly well-formed ones with random
    // content, steered now and then toward the forms the filter rejects.
    task automatic append_char();
        int         pick;
        logic [7:0] lead;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            text_q.push_back(8'($urandom_range(8'h00, 8'h7F)));
        end
        else if (pick < 42) begin
            // Two-byte form; C0 and C1 leads appear under broken sequences.
            text_q.push_back(8'($urandom_range(8'hC2, 8'hDF)));
            text_q.push_back(trail_byte());
        end
        else if (pick < 60) begin
            b1 = trail_byte();
            b2 = trail_byte();
            case ($urandom_range(0, 5))
                0: lead = 8'hE0;    // overlong when b1 is below A0
                1: lead = 8'hED;    // surrogate when b1 is A0 or above
                2: begin
                    // Noncharacters at the top of the plane and FDD0-FDEF.
                    lead = 8'hEF;
                    if ($urandom_range(0, 1) == 0) begin
                        b1 = 8'hBF;
                        b2 = 8'hBE | 8'($urandom_range(0, 1));
                    end
                    else begin
                        b1 = 8'hB7;
                        b2 = 8'($urandom_range(8'h8C, 8'hB3));
                    end
                end
                default: lead = 8'($urandom_range(8'hE0, 8'hEF));
            endcase
            text_q.push_back(lead);
            text_q.push_back(b1);
            text_q.push_back(b2);
        end
        else if (pick < 76) begin
            // Four-byte form; F0 with 80-8F is plane 0, F4 with 90 and up
            // and F5-F7 lie past plane 16.
            lead = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(8'hF0, 8'hF4))
                                              : 8'($urandom_range(8'hF5, 8'hF7));
            b1 = trail_byte();
            b2 = trail_byte();
            b3 = trail_byte();
            if ($urandom_range(0, 4) == 0) begin
                b1[3:0] = 4'hF;
                b2      = 8'hBF;
                b3      = 8'hBE | 8'($urandom_range(0, 1));
            end
            text_q.push_back(lead);
            text_q.push_back(b1);
            text_q.push_back(b2);
            text_q.push_back(b3);
        end
        else if (pick < 90) begin
            // Broken sequence: a lead cut short by an ASCII byte.
            text_q.push_back(8'($urandom_range(8'hC0, 8'hF7)));
            repeat ($urandom_range(0, 2)) text_q.push_back(trail_byte());
            text_q.push_back(8'($urandom_range(8'h00, 8'h7F)));
        end
        else begin
            text_q.push_back(8'($urandom_range(8'h00, 8'hFF)));
        end
    endtask

    // Queues random strings of a few characters each until about n bytes
    // have gone in. The final byte of each string carries the last flag.
    task automatic add_utf8_strings(input int n);
        int target;
        target = pushed_cnt + n;
        while (pushed_cnt < target) begin
            text_q.delete();
            repeat ($urandom_range(1, 6)) append_char();
            foreach (text_q[i]) begin
                add_byte(text_q[i], i == text_q.size() - 1);
            end
        end
    endtask

    // Raw bytes for pass-through, with string ends scattered among them.
    task automatic add_raw_bytes(input int n);
        repeat (n) begin
            add_byte(8'($urandom_range(8'h00, 8'hFF)), $urandom_range(0, 7) == 0);
        end
    endtask

    // Waits until every queued byte has been taken and every expected result
    // has come, then gives the block time to finish work that yields nothing.
    task automatic wait_drained();
        while (taken_cnt != pushed_cnt || kept_q.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes the mode register; only called while the block is idle.
    task automatic write_mode(input logic mode);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        utf8_mode_q = mode;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : stim_proc
        logic [7:0] corner_bytes [28];

        // Directed string: ASCII extremes including the zero byte, an
        // overlong two-byte lead, an overlong three-byte form, a surrogate,
        // the FFFE and FDD0 noncharacters, a good four-byte form, one past
        // plane 16, a bad lead, and a sequence still unfinished at the end,
        // which closes its string with a bare end marker.
        corner_bytes = '{
            8'h00, 8'h7F, 8'hC1, 8'hDF, 8'hBF,
            8'hE0, 8'h9F, 8'hBF,
            8'hED, 8'hA0, 8'h80,
            8'hEF, 8'hBF, 8'hBE,
            8'hEF, 8'hB7, 8'h90,
            8'hF0, 8'h90, 8'h80, 8'h80,
            8'hF4, 8'h90, 8'h80, 8'h80,
            8'hF8,
            8'hE2, 8'h82
        };

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = MODE_UTF8;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.in_last = 1'b0;
        out_ch.ready  = 1'b0;
        no_idle       = 1'b0;
        utf8_mode_q   = MODE_UTF8;
        held_n        = 0;
        pushed_cnt    = 0;
        taken_cnt     = 0;
        err_n         = 0;
        foreach (held_bytes[i]) begin
            held_bytes[i] = 8'h00;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The mode comes out of reset set to validation.
        foreach (corner_bytes[i]) begin
            add_byte(corner_bytes[i], i == 27);
        end
        wait_drained();

        // Random validation phase. It ends inside a character and with no
        // last flag, so the switch to pass-through has held bytes to discard.
        add_utf8_strings(90);
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b0);
        wait_drained();

        write_mode(MODE_PASS);
        add_raw_bytes(50);
        wait_drained();

        // Full-rate phase: neither side idles.
        write_mode(MODE_UTF8);
        no_idle = 1'b1;
        add_utf8_strings(110);
        wait_drained();
        no_idle = 1'b0;

        write_mode(MODE_PASS);
        add_raw_bytes(20);
        wait_drained();

        write_mode(MODE_UTF8);
        add_utf8_strings(50);
        wait_drained();

        if (err_n == 0 && kept_q.size() == 0) begin
            $display("tb_utf8_stream_validator_filter_top OK");
        end
        else begin
            $display("tb_utf8_stream_validator_filter_top NOT OK");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog_proc
        #4_000_000;
        $display("tb_utf8_stream_validator_filter_top NOT OK");
        $finish;
    end

endmodule
